// ===== hw/rtl/dpp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpp_pkg
// Shared types and constants for the depth pixel to point pipeline.
// ---------------------------------------------------------------------------
package dpp_pkg;

	// field widths
	localparam int PIX_W   = 10;
	localparam int CEN_W   = 14;
	localparam int FOC_W   = 16;
	localparam int DEP_W   = 16;
	localparam int LIM_W   = 32;
	localparam int COL_W   = 8;
	localparam int XY_W    = 40;
	localparam int Z_W     = 32;
	localparam int MAG_W   = 14;
	localparam int FRAC_W  = 16;

	// divider widths: numerator is |diff| * depth * 2^16, denominator scale * focal
	localparam int NUM_W   = MAG_W + DEP_W + FRAC_W;
	localparam int DEN_W   = 2 * FOC_W;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam int MAX_ROWS_DEF = 1024;
	localparam int MAX_COLS_DEF = 1024;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_CENTRE  = 3'd0,
		REG_COL_CENTRE  = 3'd1,
		REG_ROW_FOCAL   = 3'd2,
		REG_COL_FOCAL   = 3'd3,
		REG_DEPTH_SCALE = 3'd4,
		REG_RANGE_LIMIT = 3'd5
	} reg_idx_t;

	// reset values
	localparam logic [CEN_W-1:0] ROW_CENTRE_RST  = 14'd3840;
	localparam logic [CEN_W-1:0] COL_CENTRE_RST  = 14'd5120;
	localparam logic [FOC_W-1:0] ROW_FOCAL_RST   = 16'd8400;
	localparam logic [FOC_W-1:0] COL_FOCAL_RST   = 16'd8400;
	localparam logic [FOC_W-1:0] DEPTH_SCALE_RST = 16'd1000;
	localparam logic [LIM_W-1:0] RANGE_LIMIT_RST = 32'd327680;

	// item sideband that travels alongside the dividers
	typedef struct packed {
		logic             vld;
		logic             neg_x;
		logic             neg_y;
		logic [COL_W-1:0] ca;
		logic [COL_W-1:0] cb;
		logic [COL_W-1:0] cc;
	} side_t;

endpackage

// ===== hw/rtl/dpp_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpp_front
// Stages 1 and 2: offsets, drop of empty or off-image pixels, products that
// form the divider numerators and denominators.
// ---------------------------------------------------------------------------
module dpp_front #(
	parameter int MAX_ROWS = dpp_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = dpp_pkg::MAX_COLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [dpp_pkg::PIX_W-1:0]   pixel_row,
	input  logic [dpp_pkg::PIX_W-1:0]   pixel_col,
	input  logic [dpp_pkg::DEP_W-1:0]   depth_raw,
	input  logic [dpp_pkg::COL_W-1:0]   colour_a,
	input  logic [dpp_pkg::COL_W-1:0]   colour_b,
	input  logic [dpp_pkg::COL_W-1:0]   colour_c,
	input  logic [dpp_pkg::CEN_W-1:0]   row_centre,
	input  logic [dpp_pkg::CEN_W-1:0]   col_centre,
	input  logic [dpp_pkg::FOC_W-1:0]   row_focal,
	input  logic [dpp_pkg::FOC_W-1:0]   col_focal,
	input  logic [dpp_pkg::FOC_W-1:0]   depth_scale,
	output logic [dpp_pkg::NUM_W-1:0]   num_x_s2,
	output logic [dpp_pkg::NUM_W-1:0]   num_y_s2,
	output logic [dpp_pkg::NUM_W-1:0]   num_z_s2,
	output logic [dpp_pkg::DEN_W-1:0]   den_x_s1,
	output logic [dpp_pkg::DEN_W-1:0]   den_y_s1,
	output logic [dpp_pkg::DEN_W-1:0]   den_z_s1,
	output dpp_pkg::side_t              side_s2
);
	import dpp_pkg::*;

	localparam int PROD_W = MAG_W + DEP_W;

	logic signed [MAG_W:0] dr, dc;
	logic [FOC_W-1:0]      scale_e, fr_e, fc_e;
	logic                  in_img;
	side_t                 side_d, side_s1;
	logic [MAG_W-1:0]      mag_x_s1, mag_y_s1;
	logic [DEP_W-1:0]      depth_s1;

	// offsets in sixteenths of a pixel
	assign dr = $signed({1'b0, pixel_row, 4'b0000}) - $signed({1'b0, row_centre});
	assign dc = $signed({1'b0, pixel_col, 4'b0000}) - $signed({1'b0, col_centre});

	// a zero scale or focal acts as one
	assign scale_e = (depth_scale == '0) ? FOC_W'(1) : depth_scale;
	assign fr_e    = (row_focal == '0) ? FOC_W'(1) : row_focal;
	assign fc_e    = (col_focal == '0) ? FOC_W'(1) : col_focal;

	assign in_img = (32'(pixel_row) < 32'(MAX_ROWS)) && (32'(pixel_col) < 32'(MAX_COLS));

	always_comb begin
		side_d.vld   = in_valid && in_img && (depth_raw != '0);
		side_d.neg_x = dr[MAG_W];
		side_d.neg_y = dc[MAG_W];
		side_d.ca    = colour_a;
		side_d.cb    = colour_b;
		side_d.cc    = colour_c;
	end

	// stage 1: magnitudes, denominators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (adv) begin
			side_s1 <= side_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_x_s1 <= dr[MAG_W] ? MAG_W'(-dr) : dr[MAG_W-1:0];
			mag_y_s1 <= dc[MAG_W] ? MAG_W'(-dc) : dc[MAG_W-1:0];
			depth_s1 <= depth_raw;
		end
		den_x_s1 <= DEN_W'(scale_e) * DEN_W'(fr_e);
		den_y_s1 <= DEN_W'(scale_e) * DEN_W'(fc_e);
		den_z_s1 <= DEN_W'(scale_e);
	end

	// stage 2: numerators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (adv) begin
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_x_s2 <= {PROD_W'(mag_x_s1) * PROD_W'(depth_s1), {FRAC_W{1'b0}}};
			num_y_s2 <= {PROD_W'(mag_y_s1) * PROD_W'(depth_s1), {FRAC_W{1'b0}}};
			num_z_s2 <= NUM_W'({depth_s1, {FRAC_W{1'b0}}});
		end
	end

endmodule

// ===== hw/rtl/dpp_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpp_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module dpp_div (
	input  logic                        clk,
	input  logic                        adv,
	input  logic [dpp_pkg::NUM_W-1:0]   num,
	input  logic [dpp_pkg::DEN_W-1:0]   den,
	output logic [dpp_pkg::NUM_W-1:0]   quo
);
	import dpp_pkg::*;

	// shifting numerator/quotient word and partial remainder per stage
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] rem_s [NUM_W];

	genvar k;
	generate
		for (k = 0; k < NUM_W; k++) begin : g_stage
			logic [NUM_W-1:0] nq_prev;
			logic [DEN_W-1:0] rem_prev;
			logic [DEN_W:0]   trial;
			logic             ge;

			if (k == 0) begin : g_first
				assign nq_prev  = num;
				assign rem_prev = '0;
			end else begin : g_next
				assign nq_prev  = nq_s[k-1];
				assign rem_prev = rem_s[k-1];
			end

			// bring down one numerator bit, subtract if it fits
			assign trial = {rem_prev, nq_prev[NUM_W-1]};
			assign ge    = trial >= {1'b0, den};

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k] <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
					nq_s[k]  <= {nq_prev[NUM_W-2:0], ge};
				end
			end
		end
	endgenerate

	assign quo = nq_s[NUM_W-1];

endmodule

// ===== hw/rtl/dpp_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpp_back
// Last stage: sign, range drop, 40-bit saturation and the output register.
// ---------------------------------------------------------------------------
module dpp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  dpp_pkg::side_t              side,
	input  logic [dpp_pkg::NUM_W-1:0]   qx,
	input  logic [dpp_pkg::NUM_W-1:0]   qy,
	input  logic [dpp_pkg::NUM_W-1:0]   qz,
	input  logic [dpp_pkg::LIM_W-1:0]   range_limit,
	output logic                        out_valid_q,
	output logic [dpp_pkg::XY_W-1:0]    point_x,
	output logic [dpp_pkg::XY_W-1:0]    point_y,
	output logic [dpp_pkg::Z_W-1:0]     point_z,
	output logic [dpp_pkg::COL_W-1:0]   red,
	output logic [dpp_pkg::COL_W-1:0]   green,
	output logic [dpp_pkg::COL_W-1:0]   blue
);
	import dpp_pkg::*;

	localparam logic [NUM_W-1:0] SAT_MAG = NUM_W'(1) << (XY_W - 1);
	localparam logic [XY_W-1:0]  SAT_NEG = XY_W'(1) << (XY_W - 1);

	logic             keep;
	logic [XY_W-1:0]  x_d, y_d;

	// only the positive side is range checked
	assign keep = side.vld
		&& !(!side.neg_x && (qx > NUM_W'(range_limit)))
		&& !(!side.neg_y && (qy > NUM_W'(range_limit)));

	// negative side saturates; positive kept values do not exceed the limit
	always_comb begin
		if (!side.neg_x)          x_d = qx[XY_W-1:0];
		else if (qx >= SAT_MAG)   x_d = SAT_NEG;
		else                      x_d = XY_W'(-qx[XY_W-1:0]);
		if (!side.neg_y)          y_d = qy[XY_W-1:0];
		else if (qy >= SAT_MAG)   y_d = SAT_NEG;
		else                      y_d = XY_W'(-qy[XY_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_x <= x_d;
			point_y <= y_d;
			point_z <= qz[Z_W-1:0];
			red     <= side.ca;
			green   <= side.cb;
			blue    <= side.cc;
		end
	end

endmodule

// ===== hw/rtl/depth_pixel_to_point_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// depth_pixel_to_point_unit
// Pinhole back-projection of depth pixels into colored 3D points.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | pixel_row, pixel_col, depth_raw, colour_*
//  out     | out_valid/out_stall| point_x, point_y, point_z, red/green/blue
//  cfg     | cfg_we             | cfg_idx, cfg_wdata
//
//  One item per clock while not stalled. Results pass through two product stages,
//  then the bit-per-stage dividers and then the output stage.
//  The whole pipeline moves together; out_stall with a held result freezes it
//  and in_stall rises. Pixels with zero depth, off-image or out of range
//  leave as bubbles. Reset clears valid bits and restores register defaults.
// ---------------------------------------------------------------------------
module depth_pixel_to_point_unit #(
	parameter int MAX_ROWS = dpp_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = dpp_pkg::MAX_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dpp_pkg::PIX_W-1:0]     pixel_row,
	input  logic [dpp_pkg::PIX_W-1:0]     pixel_col,
	input  logic [dpp_pkg::DEP_W-1:0]     depth_raw,
	input  logic [dpp_pkg::COL_W-1:0]     colour_a,
	input  logic [dpp_pkg::COL_W-1:0]     colour_b,
	input  logic [dpp_pkg::COL_W-1:0]     colour_c,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [dpp_pkg::XY_W-1:0] point_x,
	output logic signed [dpp_pkg::XY_W-1:0] point_y,
	output logic [dpp_pkg::Z_W-1:0]       point_z,
	output logic [dpp_pkg::COL_W-1:0]     red,
	output logic [dpp_pkg::COL_W-1:0]     green,
	output logic [dpp_pkg::COL_W-1:0]     blue,
	input  logic                          cfg_we,
	input  logic [dpp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [dpp_pkg::CFG_DAT_W-1:0] cfg_wdata
);
	import dpp_pkg::*;

	logic [CEN_W-1:0] row_centre_q, col_centre_q;
	logic [FOC_W-1:0] row_focal_q, col_focal_q, depth_scale_q;
	logic [LIM_W-1:0] range_limit_q;

	logic             adv;
	logic [NUM_W-1:0] num_x_s2, num_y_s2, num_z_s2;
	logic [DEN_W-1:0] den_x_s1, den_y_s1, den_z_s1;
	logic [NUM_W-1:0] qx, qy, qz;
	side_t            side_s2;
	side_t            side_s [NUM_W];
	logic [XY_W-1:0]  px, py;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_centre_q  <= ROW_CENTRE_RST;
			col_centre_q  <= COL_CENTRE_RST;
			row_focal_q   <= ROW_FOCAL_RST;
			col_focal_q   <= COL_FOCAL_RST;
			depth_scale_q <= DEPTH_SCALE_RST;
			range_limit_q <= RANGE_LIMIT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_ROW_CENTRE:  row_centre_q  <= cfg_wdata[CEN_W-1:0];
				REG_COL_CENTRE:  col_centre_q  <= cfg_wdata[CEN_W-1:0];
				REG_ROW_FOCAL:   row_focal_q   <= cfg_wdata[FOC_W-1:0];
				REG_COL_FOCAL:   col_focal_q   <= cfg_wdata[FOC_W-1:0];
				REG_DEPTH_SCALE: depth_scale_q <= cfg_wdata[FOC_W-1:0];
				REG_RANGE_LIMIT: range_limit_q <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline moves whenever the output register is free or being taken
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	dpp_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (in_valid),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.depth_raw   (depth_raw),
		.colour_a    (colour_a),
		.colour_b    (colour_b),
		.colour_c    (colour_c),
		.row_centre  (row_centre_q),
		.col_centre  (col_centre_q),
		.row_focal   (row_focal_q),
		.col_focal   (col_focal_q),
		.depth_scale (depth_scale_q),
		.num_x_s2    (num_x_s2),
		.num_y_s2    (num_y_s2),
		.num_z_s2    (num_z_s2),
		.den_x_s1    (den_x_s1),
		.den_y_s1    (den_y_s1),
		.den_z_s1    (den_z_s1),
		.side_s2     (side_s2)
	);

	dpp_div u_div_x (.clk(clk), .adv(adv), .num(num_x_s2), .den(den_x_s1), .quo(qx));
	dpp_div u_div_y (.clk(clk), .adv(adv), .num(num_y_s2), .den(den_y_s1), .quo(qy));
	dpp_div u_div_z (.clk(clk), .adv(adv), .num(num_z_s2), .den(den_z_s1), .quo(qz));

	// sideband delay matching the divider depth
	genvar k;
	generate
		for (k = 0; k < NUM_W; k++) begin : g_side
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					side_s[k] <= '0;
				end else if (adv) begin
					side_s[k] <= (k == 0) ? side_s2 : side_s[(k == 0) ? 0 : k-1];
				end
			end
		end
	endgenerate

	dpp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.side        (side_s[NUM_W-1]),
		.qx          (qx),
		.qy          (qy),
		.qz          (qz),
		.range_limit (range_limit_q),
		.out_valid_q (out_valid),
		.point_x     (px),
		.point_y     (py),
		.point_z     (point_z),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

	assign point_x = $signed(px);
	assign point_y = $signed(py);

	// a delivered point always has depth behind it
	a_z_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (point_z != '0))
		else $error("point with zero Z");

	// positive coordinates never exceed the range limit
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !point_x[XY_W-1]) |-> (px <= XY_W'(range_limit_q)))
		else $error("X above range limit");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !point_y[XY_W-1]) |-> (py <= XY_W'(range_limit_q)))
		else $error("Y above range limit");

	// a new result only appears on a cycle the pipeline advanced
	a_load_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_stall))
		else $error("output loaded while frozen");

endmodule
